/* rtl/lda_pkg.sv */
// ----------------------------------------------------------------------------
// lda_pkg
// shared types and constants of the two-class linear discriminant unit
// ----------------------------------------------------------------------------
package lda_pkg;

	localparam int DEF_MAX_FEATURES = 32;
	localparam int QUEUE_DEPTH      = 4;

	localparam int LABEL_W   = 8;
	localparam int FCOUNT_W  = 6;
	localparam int SLOT_W    = 6;
	localparam int COEF_W    = 24;
	localparam int FEAT_W    = 16;
	localparam int PROD_W    = COEF_W + FEAT_W;
	localparam int ACC_W     = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	// opcodes
	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_FEATURE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_ONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_TWO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FCOUNT    = 2'd2;

	localparam logic [LABEL_W-1:0]  CLASS_ONE_RST = 8'd0;
	localparam logic [LABEL_W-1:0]  CLASS_TWO_RST = 8'd1;
	localparam logic [FCOUNT_W-1:0] FCOUNT_RST    = 6'd32;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	// one classified feature beat, front to back
	typedef struct packed {
		logic                     first;
		logic                     last;
		logic                     err;
		logic signed [COEF_W-1:0] bias;
		logic signed [COEF_W-1:0] weight;
		logic signed [FEAT_W-1:0] feature;
	} lda_entry_t;

endpackage

/* rtl/lda_in_if.sv */
// ----------------------------------------------------------------------------
// lda_in_if
// input channel: coefficient writes and feature samples
// ----------------------------------------------------------------------------
interface lda_in_if;
	import lda_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     opcode;
	logic [SLOT_W-1:0]        coef_index;
	logic signed [COEF_W-1:0] coef_value;
	logic signed [FEAT_W-1:0] feature_value;
	logic                     last_feature;

	modport source (
		output valid, opcode, coef_index, coef_value, feature_value, last_feature,
		input  ready
	);
	modport sink (
		input  valid, opcode, coef_index, coef_value, feature_value, last_feature,
		output ready
	);
endinterface

/* rtl/lda_out_if.sv */
// ----------------------------------------------------------------------------
// lda_out_if
// result channel: score, label and size error
// ----------------------------------------------------------------------------
interface lda_out_if;
	import lda_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [ACC_W-1:0] score;
	logic [LABEL_W-1:0]      class_label;
	logic                    size_error;

	modport source (
		output valid, score, class_label, size_error,
		input  ready
	);
	modport sink (
		input  valid, score, class_label, size_error,
		output ready
	);
endinterface

/* rtl/lda_ram.sv */
// ----------------------------------------------------------------------------
// lda_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module lda_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* rtl/lda_front.sv */
// ----------------------------------------------------------------------------
// lda_front
// accepts beats, stores coefficients, tags feature beats for the back end
// ----------------------------------------------------------------------------
module lda_front #(
	parameter int MAX_FEATURES = 32,
	parameter int QDEPTH       = 4,
	localparam int AW          = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
	localparam int CW          = $clog2(MAX_FEATURES + 2),
	localparam int QCW         = $clog2(QDEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	lda_in_if.sink                         samples,
	input  logic [lda_pkg::FCOUNT_W-1:0]   feature_count,
	input  logic [QCW-1:0]                 q_count,
	output logic                           push,
	output lda_pkg::lda_entry_t            push_entry
);
	import lda_pkg::*;

	logic                     acc_beat;
	logic                     is_wr;
	logic                     is_feat;
	logic [15:0]              slot_m1;
	logic                     slot_ok;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr;
	logic [COEF_W-1:0]        ram_rdata;
	logic                     w_ok;
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            cnt_nxt;
	logic                     fc_bad;
	logic                     err;
	logic [QCW:0]             used;
	logic signed [COEF_W-1:0] bias_q;

	logic                     v_s1;
	logic                     first_s1;
	logic                     last_s1;
	logic                     err_s1;
	logic                     wok_s1;
	logic signed [COEF_W-1:0] bias_s1;
	logic signed [FEAT_W-1:0] feat_s1;

	// credit: queue entries plus the beat in flight
	assign used          = {1'b0, q_count} + (QCW+1)'(v_s1);
	assign samples.ready = used < (QCW+1)'(QDEPTH);

	assign acc_beat = samples.valid && samples.ready;
	assign is_wr    = acc_beat && (samples.opcode == OP_WRITE);
	assign is_feat  = acc_beat && (samples.opcode == OP_FEATURE);

	assign slot_m1   = 16'(samples.coef_index) - 16'd1;
	assign slot_ok   = 32'(samples.coef_index) <= MAX_FEATURES;
	assign ram_we    = is_wr && slot_ok && (samples.coef_index != '0);
	assign ram_waddr = slot_m1[AW-1:0];

	assign w_ok    = 32'(cnt_q) < MAX_FEATURES;
	assign cnt_nxt = w_ok ? cnt_q + CW'(1) : CW'(MAX_FEATURES + 1);
	assign fc_bad  = (feature_count == '0) || (32'(feature_count) > MAX_FEATURES);
	assign err     = fc_bad || (16'(cnt_nxt) != 16'(feature_count));

	lda_ram #(
		.WIDTH (COEF_W),
		.DEPTH (MAX_FEATURES)
	) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (samples.coef_value),
		.re    (is_feat),
		.raddr (cnt_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// bias kept apart so the first feature needs one table read only
	always_ff @(posedge clk) begin
		if (is_wr && (samples.coef_index == '0)) begin
			bias_q <= samples.coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= is_feat;
			if (is_feat) begin
				cnt_q <= samples.last_feature ? '0 : cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_feat) begin
			first_s1 <= cnt_q == '0;
			last_s1  <= samples.last_feature;
			err_s1   <= err;
			wok_s1   <= w_ok;
			bias_s1  <= bias_q;
			feat_s1  <= samples.feature_value;
		end
	end

	assign push               = v_s1;
	assign push_entry.first   = first_s1;
	assign push_entry.last    = last_s1;
	assign push_entry.err     = err_s1;
	assign push_entry.bias    = bias_s1;
	assign push_entry.weight  = wok_s1 ? $signed(ram_rdata) : '0;
	assign push_entry.feature = feat_s1;
endmodule

/* rtl/lda_queue.sv */
// ----------------------------------------------------------------------------
// lda_queue
// short fifo of tagged feature beats between front and back
// ----------------------------------------------------------------------------
module lda_queue #(
	parameter int DEPTH = 4,
	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int QCW  = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lda_pkg::lda_entry_t push_entry,
	input  logic                pop,
	output logic                pop_valid,
	output lda_pkg::lda_entry_t pop_entry,
	output logic [QCW-1:0]      count
);
	import lda_pkg::*;

	lda_entry_t     mem_q [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [QCW-1:0] count_q;
	logic           do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign pop_valid = count_q != '0;
	assign pop_entry = mem_q[rptr_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (32'(rptr_q) == DEPTH - 1) ? '0 : rptr_q + PW'(1);
			end
			count_q <= count_q + QCW'(push) - QCW'(do_pop);
		end
	end
endmodule

/* rtl/lda_back.sv */
// ----------------------------------------------------------------------------
// lda_back
// multiply, saturating accumulate and result register
// ----------------------------------------------------------------------------
module lda_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  lda_pkg::lda_entry_t           q_entry,
	output logic                          q_pop,
	input  logic [lda_pkg::LABEL_W-1:0]   class_one_label,
	input  logic [lda_pkg::LABEL_W-1:0]   class_two_label,
	lda_out_if.source                     results
);
	import lda_pkg::*;

	logic                     adv;
	logic signed [PROD_W-1:0] prod;

	logic                     v_s1;
	logic                     first_s1;
	logic                     last_s1;
	logic                     err_s1;
	logic signed [COEF_W-1:0] bias_s1;
	logic signed [PROD_W-1:0] prod_s1;

	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  base;
	logic signed [ACC_W:0]    sum_wide;
	logic signed [ACC_W-1:0]  sum;
	logic signed [ACC_W-1:0]  score;

	logic                     res_v_q;
	logic signed [ACC_W-1:0]  res_score_q;
	logic [LABEL_W-1:0]       res_label_q;
	logic                     res_err_q;

	assign adv   = !res_v_q || results.ready;
	assign q_pop = adv && q_valid;

	assign prod = PROD_W'(q_entry.weight) * PROD_W'(q_entry.feature);

	always_comb begin
		base     = first_s1 ? {{(ACC_W-COEF_W-8){bias_s1[COEF_W-1]}}, bias_s1, 8'd0} : acc_q;
		sum_wide = {base[ACC_W-1], base} + (ACC_W+1)'(prod_s1);
		if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
			sum = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			sum = sum_wide[ACC_W-1:0];
		end
		score = (sum == ACC_MIN) ? ACC_MAX : -sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			acc_q   <= '0;
			res_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= q_valid;
			res_v_q <= v_s1 && last_s1;
			if (v_s1) begin
				acc_q <= sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			first_s1 <= q_entry.first;
			last_s1  <= q_entry.last;
			err_s1   <= q_entry.err;
			bias_s1  <= q_entry.bias;
			prod_s1  <= prod;
		end
		if (adv && v_s1 && last_s1) begin
			res_err_q   <= err_s1;
			res_score_q <= err_s1 ? '0 : score;
			res_label_q <= err_s1 ? '0 : (score[ACC_W-1] ? class_one_label : class_two_label);
		end
	end

	assign results.valid       = res_v_q;
	assign results.score       = res_score_q;
	assign results.class_label = res_label_q;
	assign results.size_error  = res_err_q;
endmodule

/* rtl/lda_linear_classifier_unit.sv */
// ----------------------------------------------------------------------------
// lda_linear_classifier_unit
// two-class linear discriminant inference, fixed point, streaming
// ----------------------------------------------------------------------------
//  channel   | dir | handshake    | beat contents
//  ----------+-----+--------------+-------------------------------------------
//  samples   | in  | valid/ready  | opcode, coef_index, coef_value,
//            |     |              | feature_value, last_feature
//  results   | out | valid/ready  | score, class_label, size_error
//  cfg       | in  | cfg_we       | cfg_index, cfg_data (no read-back)
//
//  one beat per cycle sustained while the result side keeps up; a last feature
//  beat passes the table read, the queue write and the multiply, with the
//  accumulate landing in the result register
//  the accumulator add with saturation is the only one-cycle loop
//  arst_n clears counters, queue, pipeline valids and the accumulator; the
//  coefficient table and the bias hold garbage until written
//  a stalled result stops the back end only; the front keeps taking beats
//  until the four-entry queue, counting the beat in flight, is full
// ----------------------------------------------------------------------------
module lda_linear_classifier_unit #(
	parameter int MAX_FEATURES = lda_pkg::DEF_MAX_FEATURES,
	parameter int QDEPTH       = lda_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	lda_in_if.sink                        samples,
	lda_out_if.source                     results,
	input  logic                          cfg_we,
	input  logic [lda_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lda_pkg::CFG_DAT_W-1:0] cfg_data
);
	import lda_pkg::*;

	localparam int QCW = $clog2(QDEPTH + 1);

	// configuration registers
	logic [LABEL_W-1:0]  class_one_q;
	logic [LABEL_W-1:0]  class_two_q;
	logic [FCOUNT_W-1:0] fcount_q;

	// front to queue
	logic       push;
	lda_entry_t push_entry;
	logic [QCW-1:0] q_count;

	// queue to back
	logic       q_valid;
	logic       q_pop;
	lda_entry_t q_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_one_q <= CLASS_ONE_RST;
			class_two_q <= CLASS_TWO_RST;
			fcount_q    <= FCOUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLASS_ONE: class_one_q <= cfg_data[LABEL_W-1:0];
				CFG_CLASS_TWO: class_two_q <= cfg_data[LABEL_W-1:0];
				CFG_FCOUNT:    fcount_q    <= cfg_data[FCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// front: coefficient writes end here, feature beats get weight and tags
	lda_front #(
		.MAX_FEATURES (MAX_FEATURES),
		.QDEPTH       (QDEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.samples       (samples),
		.feature_count (fcount_q),
		.q_count       (q_count),
		.push          (push),
		.push_entry    (push_entry)
	);

	// decoupling queue
	lda_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_entry  (q_entry),
		.count      (q_count)
	);

	// back: multiply-accumulate and result beat
	lda_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_entry         (q_entry),
		.q_pop           (q_pop),
		.class_one_label (class_one_q),
		.class_two_label (class_two_q),
		.results         (results)
	);
endmodule

/* sim/lda_linear_classifier_unit_tb.sv */
// ----------------------------------------------------------------------------
// lda_linear_classifier_unit_tb
// self-checking bench for the two-class linear discriminant unit: coefficient
// writes and feature vectors go in over the sample channel, a predictor in the
// bench scores every vector and the checker compares each result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lda_linear_classifier_unit_tb;
	import lda_pkg::*;

	localparam int MAXF           = DEF_MAX_FEATURES;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int MIX_ITEMS      = 130;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic signed [FEAT_W-1:0] FEAT_MIN = {1'b1, {(FEAT_W-1){1'b0}}};
	localparam logic signed [FEAT_W-1:0] FEAT_MAX = {1'b0, {(FEAT_W-1){1'b1}}};

	localparam longint SCORE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SCORE_MIN = -SCORE_MAX - 1;

	// one beat on the sample channel
	typedef struct {
		logic                     op;
		logic [SLOT_W-1:0]        slot;
		logic signed [COEF_W-1:0] coef;
		logic signed [FEAT_W-1:0] feat;
		logic                     last;
	} sample_beat_t;

	// one classified vector
	typedef struct {
		logic signed [ACC_W-1:0] score;
		logic [LABEL_W-1:0]      label;
		logic                    size_err;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	lda_in_if  samples_ch ();
	lda_out_if results_ch ();

	lda_linear_classifier_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_ch),
		.results   (results_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state: coefficient table, running sum, features seen, registers
	logic signed [COEF_W-1:0] coef_table [0:MAXF];
	longint                   acc_sum;
	int                       feat_seen;
	logic [LABEL_W-1:0]       label_one;
	logic [LABEL_W-1:0]       label_two;
	logic [FCOUNT_W-1:0]      fcount_cfg;

	// verdicts still owed by the block, oldest first
	verdict_t pending_verdicts [$];

	int mismatch_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	function automatic longint clamp_acc(input longint x);
		if (x > SCORE_MAX)
			return SCORE_MAX;
		if (x < SCORE_MIN)
			return SCORE_MIN;
		return x;
	endfunction

	// applies one accepted beat; returns 1 when it closes a vector
	function automatic bit classify_beat(input sample_beat_t b, output verdict_t v);
		longint                   base;
		longint                   total;
		longint                   neg;
		logic signed [COEF_W-1:0] w;
		bit                       bad_size;

		v = '{score: '0, label: '0, size_err: 1'b0};
		if (b.op == OP_WRITE) begin
			// slots above the table are dropped
			if (b.slot <= MAXF)
				coef_table[b.slot] = b.coef;
			return 1'b0;
		end

		// bias enters as if weighted by a leading 1.0 (Q7.8 one is 256)
		base = (feat_seen == 0) ? 256 * longint'(coef_table[0]) : acc_sum;
		if (feat_seen < MAXF) begin
			w = coef_table[feat_seen + 1];
			feat_seen++;
		end else begin
			// surplus features carry no weight, counter parks one past the end
			w = '0;
			feat_seen = MAXF + 1;
		end
		total   = clamp_acc(base + longint'(w) * longint'(b.feat));
		acc_sum = total;
		if (!b.last)
			return 1'b0;

		bad_size = (fcount_cfg == 0) || (fcount_cfg > MAXF) || (feat_seen != fcount_cfg);
		neg      = (total == SCORE_MIN) ? SCORE_MAX : -total;
		if (bad_size) begin
			v.size_err = 1'b1;
		end else begin
			v.score = ACC_W'(neg);
			v.label = (neg < 0) ? label_one : label_two;
		end
		acc_sum   = 0;
		feat_seen = 0;
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// result side: ready driver, checker, watchdog
	// ------------------------------------------------------------------------

	// ready: a forced hold-off wins over the random stall
	always @(posedge clk) begin
		if (hold_left > 0) begin
			results_ch.ready <= 1'b0;
			hold_left--;
		end else begin
			results_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("%0t mismatch: %s", $time, what);
	endtask

	// every result beat against the oldest owed verdict, field by field
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (pending_verdicts.size() == 0) begin
				flag_mismatch("result beat with no vector outstanding");
			end else begin
				v = pending_verdicts.pop_front();
				if (results_ch.score !== v.score)
					flag_mismatch($sformatf("score got %0d want %0d",
						results_ch.score, v.score));
				if (results_ch.class_label !== v.label)
					flag_mismatch($sformatf("class_label got %0d want %0d",
						results_ch.class_label, v.label));
				if (results_ch.size_error !== v.size_err)
					flag_mismatch($sformatf("size_error got %0b want %0b",
						results_ch.size_error, v.size_err));
			end
		end
	end

	// ends the run when nothing moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((samples_ch.valid && samples_ch.ready) ||
			    (results_ch.valid && results_ch.ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("lda_linear_classifier_unit_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// offers one beat after a random gap and returns at the accepting edge
	task automatic send_beat(input sample_beat_t b);
		verdict_t v;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			samples_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samples_ch.valid         <= 1'b1;
		samples_ch.opcode        <= b.op;
		samples_ch.coef_index    <= b.slot;
		samples_ch.coef_value    <= b.coef;
		samples_ch.feature_value <= b.feat;
		samples_ch.last_feature  <= b.last;
		do
			@(posedge clk);
		while (samples_ch.ready !== 1'b1);
		if (classify_beat(b, v))
			pending_verdicts = {pending_verdicts, v};
	endtask

	// coefficient write; feature fields carry noise
	task automatic send_write(input int slot, input logic signed [COEF_W-1:0] value);
		sample_beat_t b;
		b.op   = OP_WRITE;
		b.slot = SLOT_W'(slot);
		b.coef = value;
		b.feat = FEAT_W'($urandom());
		b.last = 1'($urandom());
		send_beat(b);
	endtask

	// feature sample; coefficient fields carry noise
	task automatic send_feature(input logic signed [FEAT_W-1:0] value, input bit last);
		sample_beat_t b;
		b.op   = OP_FEATURE;
		b.slot = SLOT_W'($urandom());
		b.coef = COEF_W'($urandom());
		b.feat = value;
		b.last = last;
		send_beat(b);
	endtask

	function automatic logic signed [FEAT_W-1:0] pick_feature();
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 2))
				0: return FEAT_MIN;
				1: return FEAT_MAX;
				default: return '0;
			endcase
		end
		return FEAT_W'($urandom());
	endfunction

	function automatic int pick_slot();
		// mostly live slots, now and then a slot past the table
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(MAXF + 1, (1 << SLOT_W) - 1);
		return $urandom_range(0, MAXF);
	endfunction

	task automatic send_vector(input int len);
		for (int k = 0; k < len; k++)
			send_feature(pick_feature(), k == len - 1);
	endtask

	// register write; cfg_we drops between writes
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_CLASS_ONE: label_one  = data[LABEL_W-1:0];
			CFG_CLASS_TWO: label_two  = data[LABEL_W-1:0];
			CFG_FCOUNT:    fcount_cfg = data[FCOUNT_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering, wait for every owed verdict, then let the pipe run dry
	task automatic settle();
		samples_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idle(input int send_pct, input int recv_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// fill every slot so no vector ever reads an unwritten coefficient
	task automatic test_table_load();
		for (int s = 0; s <= MAXF; s++)
			send_write(s, COEF_W'($urandom()));
		// writes past the table are ignored
		send_write(MAXF + 1, COEF_W'($urandom()));
		send_write((1 << SLOT_W) - 1, COEF_W'($urandom()));
		settle();
		write_reg(CFG_SPARE, CFG_DAT_W'($urandom()));
	endtask

	// full-scale coefficients and features, both signs, and a zero score
	task automatic test_extremes();
		settle();
		write_reg(CFG_FCOUNT, 8'd3);
		write_reg(CFG_CLASS_ONE, 8'hFF);
		write_reg(CFG_CLASS_TWO, 8'h00);
		for (int s = 0; s <= 3; s++)
			send_write(s, COEF_MIN);
		// most positive sum, score negative
		send_feature(FEAT_MIN, 1'b0);
		send_feature(FEAT_MIN, 1'b0);
		send_feature(FEAT_MIN, 1'b1);
		// most negative sum, score positive
		send_feature(FEAT_MAX, 1'b0);
		send_feature(FEAT_MAX, 1'b0);
		send_feature(FEAT_MAX, 1'b1);
		for (int s = 0; s <= 3; s++)
			send_write(s, COEF_MAX);
		send_feature(FEAT_MIN, 1'b0);
		send_feature(FEAT_MAX, 1'b0);
		send_feature(FEAT_MIN, 1'b1);
		// all-zero table gives score zero, which takes the second label
		for (int s = 0; s <= 3; s++)
			send_write(s, '0);
		send_vector(3);
	endtask

	// short, long, overlong vectors and counts that can never match
	task automatic test_size_errors();
		settle();
		write_reg(CFG_FCOUNT, 8'd1);
		send_vector(1);
		send_vector(2);
		settle();
		write_reg(CFG_FCOUNT, 8'd0);
		send_vector(1);
		settle();
		// all ones in the data byte: count field reads 63
		write_reg(CFG_FCOUNT, 8'hFF);
		send_vector(3);
		settle();
		// upper data bits set, count field reads 3
		write_reg(CFG_FCOUNT, 8'hC3);
		send_vector(3);
		settle();
		write_reg(CFG_FCOUNT, 8'd32);
		send_vector(MAXF + 2);
		send_vector(MAXF);
		send_vector(MAXF + 1);
	endtask

	// coefficient writes landing inside a vector
	task automatic test_mid_vector_write();
		settle();
		write_reg(CFG_FCOUNT, 8'd4);
		send_feature(pick_feature(), 1'b0);
		send_feature(pick_feature(), 1'b0);
		send_write(3, COEF_W'($urandom()));
		send_write(1, COEF_W'($urandom()));
		send_write(0, COEF_W'($urandom()));
		send_write(MAXF + 8, COEF_W'($urandom()));
		send_feature(pick_feature(), 1'b0);
		send_feature(pick_feature(), 1'b1);
	endtask

	// receiver holds off while the sender keeps going, then a full drain
	task automatic test_backpressure();
		settle();
		write_reg(CFG_FCOUNT, 8'd2);
		set_idle(0, 0);
		hold_left = 80;
		for (int i = 0; i < 40; i++)
			send_feature(pick_feature(), i % 2 == 1);
		// sender pauses until every verdict is back
		settle();
		send_vector(2);
		send_vector(2);
	endtask

	// random phases: mostly well-formed vectors, some wrong lengths and writes
	task automatic run_mix(input int n_items);
		int sent;
		int len;
		int fc;
		sent = 0;
		settle();
		fc = $urandom_range(1, 12);
		write_reg(CFG_FCOUNT, CFG_DAT_W'(fc));
		write_reg(CFG_CLASS_ONE, CFG_DAT_W'($urandom()));
		write_reg(CFG_CLASS_TWO, CFG_DAT_W'($urandom()));
		while (sent < n_items) begin
			case ($urandom_range(0, 9))
				0: begin
					send_write(pick_slot(), COEF_W'($urandom()));
					sent++;
				end
				1: begin
					len = $urandom_range(1, fc + 2);
					send_vector(len);
					sent += len;
				end
				default: begin
					send_vector(fc);
					sent += fc;
				end
			endcase
		end
		settle();
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------

	initial begin
		mismatch_count = 0;
		hold_left      = 0;
		set_idle(0, 0);
		acc_sum    = 0;
		feat_seen  = 0;
		label_one  = CLASS_ONE_RST;
		label_two  = CLASS_TWO_RST;
		fcount_cfg = FCOUNT_RST;

		arst_n                   <= 1'b0;
		cfg_we                   <= 1'b0;
		cfg_index                <= '0;
		cfg_data                 <= '0;
		samples_ch.valid         <= 1'b0;
		samples_ch.opcode        <= OP_WRITE;
		samples_ch.coef_index    <= '0;
		samples_ch.coef_value    <= '0;
		samples_ch.feature_value <= '0;
		samples_ch.last_feature  <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_table_load();
		test_extremes();
		test_size_errors();
		test_mid_vector_write();
		test_backpressure();

		set_idle(0, 0);
		run_mix(MIX_ITEMS);
		set_idle(49, 0);
		run_mix(MIX_ITEMS);
		set_idle(0, 49);
		run_mix(MIX_ITEMS);
		set_idle(27, 27);
		run_mix(MIX_ITEMS);

		settle();
		if (mismatch_count == 0)
			$display("lda_linear_classifier_unit_tb: PASS");
		else
			$display("lda_linear_classifier_unit_tb: FAIL");
		$finish;
	end

endmodule

/* lda_linear_classifier_unit.f */
rtl/lda_pkg.sv
rtl/lda_in_if.sv
rtl/lda_out_if.sv
rtl/lda_ram.sv
rtl/lda_front.sv
rtl/lda_queue.sv
rtl/lda_back.sv
rtl/lda_linear_classifier_unit.sv
sim/lda_linear_classifier_unit_tb.sv
